// ===== rtl/brte_pkg.sv =====
// ---------------------------------------------------------------------------
// brte_pkg: shared constants for the battery remaining-time estimator
// Field widths of the update and result beats, and the scaling constants.
// ---------------------------------------------------------------------------
package brte_pkg;

  localparam int PCT_W   = 7;   // charge percent
  localparam int BCNT_W  = 4;   // present battery count
  localparam int TIME_W  = 32;  // seconds timestamp
  localparam int MIN_W   = 27;  // remaining minutes
  localparam int DPCT_W  = 8;   // percent difference, wraps mod 256
  localparam int DVSR_W  = 14;  // percent difference times 60

  localparam int FULL_PERCENT = 100;
  localparam int SECS_PER_MIN = 60;

endpackage

// ===== rtl/brte_if.sv =====
// ---------------------------------------------------------------------------
// brte_in_if / brte_out_if: valid/ready channels of the estimator
// Update beats in, result beats out.
// ---------------------------------------------------------------------------
interface brte_in_if;
  import brte_pkg::*;

  logic              valid;
  logic              ready;
  logic [PCT_W-1:0]  charge_percent;
  logic              charging;
  logic [BCNT_W-1:0] present_count;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, charge_percent, charging, present_count, now_seconds,
                  input ready);
  modport sink   (input valid, charge_percent, charging, present_count, now_seconds,
                  output ready);
endinterface

interface brte_out_if;
  import brte_pkg::*;

  logic             valid;
  logic             ready;
  logic [MIN_W-1:0] remaining_minutes;
  logic             redraw;

  modport source (output valid, remaining_minutes, redraw, input ready);
  modport sink   (input valid, remaining_minutes, redraw, output ready);
endinterface

// ===== rtl/battery_remaining_time_estimator_core.sv =====
// ---------------------------------------------------------------------------
// battery_remaining_time_estimator_core: minutes-to-empty/full estimator
// Keeps a short percent/time history and scales seconds per percent.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per battery update (percent, charger flag, battery
//            count, seconds stamp). ready is high only while the core idles.
//   out_ch : exactly one result beat per update (minutes, redraw flag).
//            The result is held in registers until the receiver takes it;
//            no new update is taken before that.
//   Steps:   an update that is unchanged, or that clears the estimate,
//            goes from idle straight to its result beat. A full estimate
//            runs difference, multiply and a 32-step restoring divide
//            before its result beat; a zero percent difference skips the
//            multiply and the divide.
//   Reset (rst_n low, synchronous): history empty, estimate 0, the next
//            changed update only clears the estimate. No clearing pass.
//   Stall: while out_ch.ready is low the result and redraw stay put.
// ---------------------------------------------------------------------------
module battery_remaining_time_estimator_core #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  brte_in_if.sink    in_ch,
  brte_out_if.source out_ch
);
  import brte_pkg::*;

  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int STEP_W = $clog2(TIME_W);

  typedef enum logic [2:0] {S_IDLE, S_DIFF, S_MUL, S_DIV, S_OUT} state_t;

  // control state
  state_t            state_r, state_nxt;
  logic              prev_chg_r, prev_chg_nxt;
  logic [PCT_W-1:0]  prev_pct_r, prev_pct_nxt;
  logic [BCNT_W-1:0] prev_cnt_r, prev_cnt_nxt;
  logic              first_r, first_nxt;
  logic              est_chg_r, est_chg_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [MIN_W-1:0]  estimate_r, estimate_nxt;
  logic              redraw_r, redraw_nxt;

  // history shift line, entry 0 newest
  logic [PCT_W-1:0]  hist_pct_r  [HISTORY_DEPTH];
  logic [TIME_W-1:0] hist_time_r [HISTORY_DEPTH];
  logic              hist_shift;

  // datapath
  logic [TIME_W-1:0] dtime_r, dtime_nxt;
  logic [TIME_W-1:0] factor_r, factor_nxt;
  logic [DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic              in_acc;
  logic              chg_diff, cnt_diff, changed, first_eff;
  logic [FILL_W-1:0] fill_inc;
  logic [IDX_W-1:0]  oldest_idx;
  logic [DPCT_W-1:0] dpct;
  logic [DVSR_W:0]   trial;
  logic              trial_ge;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid             = (state_r == S_OUT);
  assign out_ch.remaining_minutes = estimate_r;
  assign out_ch.redraw            = redraw_r;

  assign chg_diff  = (prev_chg_r != in_ch.charging);
  assign cnt_diff  = (prev_cnt_r != in_ch.present_count);
  assign changed   = chg_diff || cnt_diff || (prev_pct_r != in_ch.charge_percent);
  assign first_eff = first_r || chg_diff || cnt_diff;

  assign fill_inc   = (fill_r < FILL_W'(HISTORY_DEPTH)) ? fill_r + 1'b1 : fill_r;
  assign oldest_idx = IDX_W'(fill_r - 1'b1);

  // percent difference, wraps mod 256
  always_comb begin
    if (est_chg_r) begin
      dpct = DPCT_W'({1'b0, hist_pct_r[0]} - {1'b0, hist_pct_r[oldest_idx]});
    end else begin
      dpct = DPCT_W'({1'b0, hist_pct_r[oldest_idx]} - {1'b0, hist_pct_r[0]});
    end
  end

  // restoring divide step: product / (dpct * 60) == (product / dpct) / 60
  assign trial    = {rem_r, quo_r[TIME_W-1]};
  assign trial_ge = (trial >= {1'b0, dvsr_r});

  always_comb begin
    state_nxt    = state_r;
    prev_chg_nxt = prev_chg_r;
    prev_pct_nxt = prev_pct_r;
    prev_cnt_nxt = prev_cnt_r;
    first_nxt    = first_r;
    est_chg_nxt  = est_chg_r;
    fill_nxt     = fill_r;
    estimate_nxt = estimate_r;
    redraw_nxt   = redraw_r;
    hist_shift   = 1'b0;
    dtime_nxt    = dtime_r;
    factor_nxt   = factor_r;
    dvsr_nxt     = dvsr_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    step_nxt     = step_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_OUT;
          if (!changed) begin
            redraw_nxt = 1'b0;
          end else begin
            redraw_nxt   = 1'b1;
            prev_chg_nxt = in_ch.charging;
            prev_pct_nxt = in_ch.charge_percent;
            prev_cnt_nxt = in_ch.present_count;
            first_nxt    = 1'b0;
            if (first_eff) begin
              estimate_nxt = '0;
            end else if (est_chg_r != in_ch.charging) begin
              // charger flipped under the estimator: flush history
              est_chg_nxt  = in_ch.charging;
              fill_nxt     = '0;
              estimate_nxt = '0;
            end else begin
              hist_shift = 1'b1;
              fill_nxt   = fill_inc;
              if (fill_inc < FILL_W'(2)) begin
                estimate_nxt = '0;
              end else begin
                state_nxt = S_DIFF;
              end
            end
          end
        end
      end
      S_DIFF: begin
        dtime_nxt = hist_time_r[0] - hist_time_r[oldest_idx];
        if (est_chg_r) begin
          factor_nxt = TIME_W'(FULL_PERCENT) - TIME_W'(hist_pct_r[0]);
        end else begin
          factor_nxt = TIME_W'(hist_pct_r[0]);
        end
        dvsr_nxt = DVSR_W'(dpct) * DVSR_W'(SECS_PER_MIN);
        if (dpct == '0) begin
          estimate_nxt = '0;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        quo_nxt   = TIME_W'(dtime_r * factor_r);
        rem_nxt   = '0;
        step_nxt  = STEP_W'(TIME_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = trial_ge ? DVSR_W'(trial - {1'b0, dvsr_r}) : DVSR_W'(trial);
        quo_nxt  = {quo_r[TIME_W-2:0], trial_ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          estimate_nxt = MIN_W'({quo_r[TIME_W-2:0], trial_ge});
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      prev_chg_r <= 1'b0;
      prev_pct_r <= '0;
      prev_cnt_r <= '0;
      first_r    <= 1'b1;
      est_chg_r  <= 1'b0;
      fill_r     <= '0;
      estimate_r <= '0;
      redraw_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prev_chg_r <= prev_chg_nxt;
      prev_pct_r <= prev_pct_nxt;
      prev_cnt_r <= prev_cnt_nxt;
      first_r    <= first_nxt;
      est_chg_r  <= est_chg_nxt;
      fill_r     <= fill_nxt;
      estimate_r <= estimate_nxt;
      redraw_r   <= redraw_nxt;
    end
  end

  // payload: no reset, entries at or above fill_r are never read
  always_ff @(posedge clk) begin
    if (hist_shift) begin
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
        hist_pct_r[k]  <= hist_pct_r[k-1];
        hist_time_r[k] <= hist_time_r[k-1];
      end
      hist_pct_r[0]  <= in_ch.charge_percent;
      hist_time_r[0] <= in_ch.now_seconds;
    end
    dtime_r  <= dtime_nxt;
    factor_r <= factor_nxt;
    dvsr_r   <= dvsr_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
  end

endmodule

// ===== rtl/brte_checker.sv =====
// ---------------------------------------------------------------------------
// brte_checker: port-level checks for the estimator core
// One update in flight at a time, one result beat per update.
// ---------------------------------------------------------------------------
module brte_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brte_pkg::MIN_W-1:0] out_minutes,
  input logic                       out_redraw
);

  // never open for a new update while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // an accepted update closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

  // one result beat per update, then back to idle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (!out_valid && in_ready))
    else $error("extra result beat or no return to idle");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_minutes) && $stable(out_redraw)))
    else $error("stalled result changed");

endmodule

bind battery_remaining_time_estimator_core brte_checker u_brte_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_minutes (out_ch.remaining_minutes),
  .out_redraw  (out_ch.redraw)
);

// ===== bench/battery_remaining_time_estimator_core_tb.sv =====
// ---------------------------------------------------------------------------
// battery_remaining_time_estimator_core_tb: self-checking bench for the core
// Drives battery updates through the input channel and checks each result beat
// against a typed-in value or an in-bench predictor of history and scaling.
// A short directed table comes first, then random discharge/charge ramps
// with noise, random gaps on both channels and a drain pause mid-run.
// ---------------------------------------------------------------------------
module battery_remaining_time_estimator_core_tb;
  import brte_pkg::*;

  localparam int HIST_DEPTH    = 5;
  localparam int RANDOM_TARGET = 775;      // updates in the random part
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int TAIL_CYCLES   = 40;       // outlasts a full estimate after accept

  typedef struct packed {
    logic [MIN_W-1:0] minutes;
    logic             redraw;
  } result_t;

  typedef struct packed {
    logic [PCT_W-1:0]  pct;
    logic              chg;
    logic [BCNT_W-1:0] cnt;
    logic [TIME_W-1:0] now;
    bit                known;     // expected result typed in below
    logic [MIN_W-1:0]  exp_min;
    logic              exp_redraw;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  brte_in_if  in_ch();
  brte_out_if out_ch();

  battery_remaining_time_estimator_core #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4-unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the core's registers after reset
  // ---------------------------------------------------------------------------
  logic              seen_chg   = 1'b0;
  logic [PCT_W-1:0]  seen_pct   = '0;
  logic [BCNT_W-1:0] seen_cnt   = '0;
  bit                clear_next = 1'b1;   // next processed update only clears
  logic              hist_chg   = 1'b0;   // charger flag the history belongs to
  logic [PCT_W-1:0]  hist_pct  [HIST_DEPTH];
  logic [TIME_W-1:0] hist_time [HIST_DEPTH];
  int                hist_fill  = 0;      // valid entries, entry 0 newest
  logic [MIN_W-1:0]  held_minutes = '0;

  result_t pending_results[$];            // expected beats, oldest first

  int  n_updates   = 0;
  int  n_processed = 0;
  int  n_nonzero   = 0;
  int  n_flushes   = 0;
  int  n_errors    = 0;
  int  cycle_count = 0;
  bit  quiet       = 1'b0;                // no new gaps or stalls start while set

  // Push into the history and scale seconds-per-percent to minutes.
  // A charger flip against the history flushes it and gives no estimate.
  function automatic logic [TIME_W-1:0] minutes_from_history(
    input logic [PCT_W-1:0]  pct,
    input logic              chg,
    input logic [TIME_W-1:0] now
  );
    logic [DPCT_W-1:0] dpct;
    logic [TIME_W-1:0] dtime;
    logic [TIME_W-1:0] factor;
    logic [TIME_W-1:0] product;
    int                oldest;
    if (hist_chg != chg) begin
      hist_chg  = chg;
      hist_fill = 0;
      n_flushes++;
      return '0;
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
      hist_pct[k]  = hist_pct[k-1];
      hist_time[k] = hist_time[k-1];
    end
    hist_pct[0]  = pct;
    hist_time[0] = now;
    if (hist_fill < HIST_DEPTH) hist_fill++;
    if (hist_fill < 2) return '0;
    oldest = hist_fill - 1;
    // 8-bit wrap of the percent difference, rising when charging
    if (chg) dpct = {1'b0, hist_pct[0]} - {1'b0, hist_pct[oldest]};
    else     dpct = {1'b0, hist_pct[oldest]} - {1'b0, hist_pct[0]};
    dtime = hist_time[0] - hist_time[oldest];
    if (dpct == '0) return '0;
    // percent above full wraps the charging factor, product wraps at 32 bits
    if (chg) factor = TIME_W'(FULL_PERCENT) - TIME_W'(pct);
    else     factor = TIME_W'(pct);
    product = dtime * factor;
    return (product / TIME_W'(dpct)) / TIME_W'(SECS_PER_MIN);
  endfunction

  function automatic result_t predict_update(
    input logic [PCT_W-1:0]  pct,
    input logic              chg,
    input logic [BCNT_W-1:0] cnt,
    input logic [TIME_W-1:0] now
  );
    result_t res;
    res.redraw = 1'b0;
    if (seen_chg != chg || seen_cnt != cnt) clear_next = 1'b1;
    if (seen_chg != chg || seen_pct != pct || seen_cnt != cnt) begin
      if (clear_next) begin
        held_minutes = '0;
        clear_next   = 1'b0;
      end else begin
        held_minutes = MIN_W'(minutes_from_history(pct, chg, now));
      end
      seen_chg   = chg;
      seen_pct   = pct;
      seen_cnt   = cnt;
      res.redraw = 1'b1;
    end
    res.minutes = held_minutes;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // One update beat: gap, drive at negedge, hold until accepted at posedge.
  // The typed-in result is queued instead of the predicted one when given.
  task automatic send_update(
    input logic [PCT_W-1:0]  pct,
    input logic              chg,
    input logic [BCNT_W-1:0] cnt,
    input logic [TIME_W-1:0] now,
    input bit                known,
    input result_t           typed
  );
    result_t want;
    int      gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.charge_percent <= pct;
    in_ch.charging       <= chg;
    in_ch.present_count  <= cnt;
    in_ch.now_seconds    <= now;
    do @(posedge clk); while (!in_ch.ready);
    want = predict_update(pct, chg, cnt, now);
    n_updates++;
    if (want.redraw) n_processed++;
    if (want.redraw && want.minutes != '0) n_nonzero++;
    pending_results.push_back(known ? typed : want);
  endtask

  // Sender holds off until every outstanding result beat has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Well-formed run: fixed charger flag and count, percent stepping toward
  // empty or full with repeats, seconds stamps advancing (sometimes wildly).
  logic [BCNT_W-1:0] ramp_cnt = 4'd1;

  task automatic run_ramp();
    logic              chg;
    logic [TIME_W-1:0] t;
    int                pct;
    int                len;
    int                r;
    chg = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) ramp_cnt = BCNT_W'($urandom_range(0, 15));
    pct = chg ? $urandom_range(0, 90) : $urandom_range(10, 100);
    if ($urandom_range(0, 7) == 0) pct = $urandom_range(95, 127);
    t   = $urandom;
    len = $urandom_range(4, 12);
    repeat (len) begin
      send_update(PCT_W'(pct), chg, ramp_cnt, t, 1'b0, '0);
      t += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, 600);
      r = $urandom_range(0, 9);
      if (r >= 2 && r < 8) pct = chg ? pct + 1 : pct - 1;
      else if (r >= 8)     pct = pct + $urandom_range(0, 6) - 3;
      pct = pct & 127;
    end
  endtask

  // Noise: anything the fields allow, percent above full included.
  task automatic run_noise();
    repeat ($urandom_range(1, 4)) begin
      send_update(PCT_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                  BCNT_W'($urandom_range(0, 15)), $urandom, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Expected values typed in only where obvious: unchanged
  // after reset, clears on charger/count change, flush, single history
  // entry, zero percent difference. Other rows go through the predictor.
  // ---------------------------------------------------------------------------
  localparam int PLAN_ROWS = 25;
  plan_row_t plan [PLAN_ROWS] = '{
    //  pct  chg  cnt    now            known  min  redraw
    '{7'd0,   1'b0, 4'd0,  32'd0,          1'b1, '0, 1'b0},  // unchanged after reset
    '{7'd60,  1'b0, 4'd1,  32'd1000,       1'b1, '0, 1'b1},  // first update clears
    '{7'd59,  1'b0, 4'd1,  32'd1100,       1'b1, '0, 1'b1},  // single entry
    '{7'd58,  1'b0, 4'd1,  32'd1220,       1'b0, '0, 1'b0},
    '{7'd58,  1'b0, 4'd1,  32'd1300,       1'b0, '0, 1'b0},  // unchanged, held estimate
    '{7'd57,  1'b0, 4'd1,  32'd1400,       1'b0, '0, 1'b0},
    '{7'd56,  1'b0, 4'd1,  32'd1460,       1'b0, '0, 1'b0},
    '{7'd55,  1'b0, 4'd1,  32'd1530,       1'b0, '0, 1'b0},  // history full
    '{7'd54,  1'b0, 4'd1,  32'd1590,       1'b0, '0, 1'b0},  // oldest drops out
    '{7'd70,  1'b0, 4'd1,  32'd1650,       1'b0, '0, 1'b0},  // rising while discharging
    '{7'd70,  1'b1, 4'd1,  32'd2000,       1'b1, '0, 1'b1},  // charger plugged: clear
    '{7'd71,  1'b1, 4'd1,  32'd2050,       1'b1, '0, 1'b1},  // history flushed
    '{7'd72,  1'b1, 4'd1,  32'd2110,       1'b1, '0, 1'b1},  // single entry
    '{7'd73,  1'b1, 4'd1,  32'd2170,       1'b0, '0, 1'b0},  // charging estimate
    '{7'd73,  1'b1, 4'd15, 32'd2200,       1'b1, '0, 1'b1},  // count change: clear
    '{7'd127, 1'b1, 4'd15, 32'd2300,       1'b0, '0, 1'b0},  // above full, factor wraps
    '{7'd126, 1'b1, 4'd15, 32'hFFFF_FFF0,  1'b0, '0, 1'b0},  // product wraps
    '{7'd125, 1'b1, 4'd15, 32'h0000_0010,  1'b0, '0, 1'b0},  // timestamp wraps
    '{7'd0,   1'b0, 4'd15, 32'd5000,       1'b1, '0, 1'b1},  // charger pulled: clear
    '{7'd40,  1'b0, 4'd15, 32'd5010,       1'b1, '0, 1'b1},  // history flushed
    '{7'd41,  1'b0, 4'd15, 32'd5020,       1'b1, '0, 1'b1},  // single entry
    '{7'd42,  1'b0, 4'd15, 32'd5080,       1'b0, '0, 1'b0},  // percent diff wraps
    '{7'd41,  1'b0, 4'd15, 32'd5140,       1'b1, '0, 1'b1},  // zero percent diff
    '{7'd41,  1'b0, 4'd15, 32'd5200,       1'b1, '0, 1'b0},  // unchanged
    '{7'd0,   1'b0, 4'd0,  32'hFFFF_FFFF,  1'b1, '0, 1'b1}   // count change: clear
  };

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, none started while quiet
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                              : $urandom_range(1, 3);
      end
    end
  end

  // Result checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (n_errors < 10)
          $display("ERROR: unexpected result beat minutes=%0d redraw=%0b",
                   out_ch.remaining_minutes, out_ch.redraw);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.remaining_minutes !== want.minutes || out_ch.redraw !== want.redraw) begin
          if (n_errors < 10)
            $display("ERROR: result mismatch minutes exp=%0d got=%0d, redraw exp=%0b got=%0b",
                     want.minutes, out_ch.remaining_minutes, want.redraw, out_ch.redraw);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: timeout after %0d cycles", cycle_count);
    $display("FAIL battery_remaining_time_estimator_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    result_t typed;
    int      random_base;
    bit      paused;
    paused = 1'b0;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      hist_pct[k]  = '0;
      hist_time[k] = '0;
    end
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.charge_percent = '0;
    in_ch.charging       = 1'b0;
    in_ch.present_count  = '0;
    in_ch.now_seconds    = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      typed.minutes = plan[i].exp_min;
      typed.redraw  = plan[i].exp_redraw;
      send_update(plan[i].pct, plan[i].chg, plan[i].cnt, plan[i].now, plan[i].known, typed);
    end
    drain_results();

    // random part: mostly ramps, some noise; every update counts
    random_base = n_updates;
    while (n_updates - random_base < RANDOM_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) run_noise();
      else                           run_ramp();
      if (!paused && n_updates - random_base >= RANDOM_TARGET / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      if (n_errors < 10)
        $display("ERROR: %0d result beats never arrived", pending_results.size());
      n_errors += pending_results.size();
    end

    $display("Covered %0d updates, %0d processed, %0d nonzero estimates, %0d history flushes",
             n_updates, n_processed, n_nonzero, n_flushes);
    $display("Errors: %0d, cycles: %0d", n_errors, cycle_count);
    if (n_errors == 0) begin
      $display("PASS battery_remaining_time_estimator_core");
    end else begin
      $display("FAIL battery_remaining_time_estimator_core");
    end
    $finish;
  end

endmodule
